[design/rcfft_pkg.sv]
`default_nettype none
package rcfft_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } item_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB,
    ST_POP_OUT
  } state_t;

  localparam logic CFG_DIRECTION   = 1'b0;
  localparam logic CFG_LOG2_LENGTH = 1'b1;
  localparam int   CFG_DATA_W      = 4;
  localparam logic DIR_FORWARD     = 1'b0;

endpackage
`default_nettype wire

[design/rcfft_front.sv]
`default_nettype none
module rcfft_front #(
  parameter int SB = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_command,
  input  wire  signed [SB-1:0]   in_sample_real,
  input  wire  signed [SB-1:0]   in_sample_imag,
  output rcfft_pkg::item_ctl_t   item,
  output logic signed [SB-1:0]   item_real,
  output logic signed [SB-1:0]   item_imag,
  input  wire                    item_take
);

  rcfft_pkg::op_t    q_op_r [0:1];
  logic [SB-1:0]     q_re_r [0:1];
  logic [SB-1:0]     q_im_r [0:1];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;
  logic              push, pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = item_take && (count_r != 2'd0);

  assign item.valid = (count_r != 2'd0);
  assign item.op    = q_op_r[rd_ptr_r];
  assign item_real  = q_re_r[rd_ptr_r];
  assign item_imag  = q_im_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wr_ptr_r] <= in_command ? rcfft_pkg::OP_POP : rcfft_pkg::OP_PUSH;
      q_re_r[wr_ptr_r] <= in_sample_real;
      q_im_r[wr_ptr_r] <= in_sample_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[design/rcfft_twiddle.sv]
`default_nettype none
module rcfft_twiddle #(
  parameter int MAXL = 10,
  parameter int TB   = 18
) (
  input  wire                   clk,
  input  wire                   en,
  input  wire                   dir,
  input  wire  [((MAXL > 1) ? MAXL - 1 : 1)-1:0] k,
  output logic signed [TB-1:0]  cos_r,
  output logic signed [TB-1:0]  sin_r
);

  localparam int KW      = (MAXL > 1) ? MAXL - 1 : 1;
  localparam int QUARTER = (1 << MAXL) / 4;
  localparam int F       = TB - 2;
  localparam longint unsigned PI_Q40 = 64'h3243F6A8886;

  function automatic longint unsigned cos_entry(input int unsigned idx);
    longint unsigned x, x2, term;
    longint          v;
    int unsigned     sh;
    x    = (PI_Q40 * idx + (64'd1 << (MAXL + 8))) >> (MAXL + 9);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    v    = 64'sd1 <<< 30;
    term = ((term * x2) >> 30) / 64'd2;   v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;  v = v + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;  v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;  v = v + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;  v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd132; v = v + longint'(term);
    term = ((term * x2) >> 30) / 64'd182; v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd240; v = v + longint'(term);
    term = ((term * x2) >> 30) / 64'd306; v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd380; v = v + longint'(term);
    term = ((term * x2) >> 30) / 64'd462; v = v - longint'(term);
    term = ((term * x2) >> 30) / 64'd552; v = v + longint'(term);
    if (v < 0) v = 0;
    if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
    sh = 30 - F;
    if (sh == 0) return longint'(v);
    return (longint'(v) + (64'd1 << (sh - 1))) >> sh;
  endfunction

  logic [TB-1:0] tw_rom [0:QUARTER];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tw
    localparam longint unsigned ENTRY = cos_entry(g);
    assign tw_rom[g] = ENTRY[TB-1:0];
  end

  localparam logic [KW-1:0] Q_IDX = KW'(QUARTER);
  localparam logic signed [TB-1:0] ONE = TB'(1) << F;

  logic signed [TB-1:0] c_c, s_c;
  logic [KW-1:0]        neg_k;

  assign neg_k = KW'(0) - k;

  always_comb begin
    if (k == '0) begin
      c_c = ONE;
      s_c = '0;
    end else if (k <= Q_IDX) begin
      c_c = tw_rom[k];
      s_c = tw_rom[Q_IDX - k];
    end else begin
      c_c = -$signed(tw_rom[neg_k]);
      s_c = tw_rom[k - Q_IDX];
    end
    if (dir == rcfft_pkg::DIR_FORWARD) s_c = -s_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_c;
      sin_r <= s_c;
    end
  end

endmodule
`default_nettype wire

[design/rcfft_back.sv]
`default_nettype none
module rcfft_back #(
  parameter int MAXL = 10,
  parameter int SB   = 16,
  parameter int TB   = 18
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  rcfft_pkg::item_ctl_t              item,
  input  wire  signed [SB-1:0]              item_real,
  input  wire  signed [SB-1:0]              item_imag,
  output logic                              item_take,
  input  wire                               cfg_valid,
  input  wire                               cfg_index,
  input  wire  [rcfft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [SB+MAXL:0]           out_bin_real,
  output logic signed [SB+MAXL:0]           out_bin_imag,
  output logic                              out_bin_valid,
  output logic                              out_last_bin
);

  localparam int W  = SB + MAXL + 1;
  localparam int F  = TB - 2;
  localparam int N  = 1 << MAXL;
  localparam int AW = MAXL;
  localparam int CW = MAXL + 1;
  localparam int KW = (MAXL > 1) ? MAXL - 1 : 1;
  localparam int PW = W + TB + 1;
  localparam logic signed [PW:0] RND = (PW+1)'(1) << (F - 1);

  rcfft_pkg::state_t state_r, state_nxt;

  logic          direction_r;
  logic [3:0]    log2_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          ready_r, ready_nxt;
  logic [3:0]    stage_r, stage_nxt;
  logic [AW-1:0] bf_r, bf_nxt;
  logic          pop_bv_r, pop_bv_nxt;
  logic          pop_last_r, pop_last_nxt;

  logic [3:0]    eff_l;
  logic [CW-1:0] n_pts;
  logic [AW-1:0] half, mask, addr_a, addr_b, jj, rev, pop_addr;
  logic [KW-1:0] tw_k;

  logic [2*W-1:0] mem [0:N-1];
  logic [2*W-1:0] rd_a_r, rd_b_r, wdata;
  logic [AW-1:0]  waddr, raddr_a;
  logic           we, re;

  logic signed [TB-1:0] cos_r, sin_r;
  logic signed [W:0]    dr, di;
  logic signed [PW-1:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic signed [W-1:0]  sum_re_r, sum_im_r, res_re_r, res_im_r;
  logic signed [PW:0]   pr, pi;

  logic out_free, out_load;

  assign eff_l = (log2_r > 4'(MAXL)) ? 4'(MAXL) : log2_r;
  assign n_pts = CW'(1) << eff_l;

  assign half   = AW'(1) << (stage_r - 4'd1);
  assign mask   = half - AW'(1);
  assign jj     = bf_r & mask;
  assign addr_a = ((bf_r >> (stage_r - 4'd1)) << stage_r) | jj;
  assign addr_b = addr_a | half;
  assign tw_k   = KW'(jj << (4'(MAXL) - stage_r));

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = rd_idx_r[AW-1-i];
  end
  assign pop_addr = rev >> (4'(MAXL) - eff_l);

  rcfft_twiddle #(.MAXL(MAXL), .TB(TB)) u_tw (
    .clk  (clk),
    .en   (state_r == rcfft_pkg::ST_BF_RD),
    .dir  (direction_r),
    .k    (tw_k),
    .cos_r(cos_r),
    .sin_r(sin_r)
  );

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rd_idx_nxt   = rd_idx_r;
    ready_nxt    = ready_r;
    stage_nxt    = stage_r;
    bf_nxt       = bf_r;
    pop_bv_nxt   = pop_bv_r;
    pop_last_nxt = pop_last_r;
    item_take    = 1'b0;
    we           = 1'b0;
    waddr        = addr_a;
    wdata        = {sum_im_r, sum_re_r};
    re           = 1'b0;
    raddr_a      = addr_a;
    out_load     = 1'b0;
    unique case (state_r)
      rcfft_pkg::ST_IDLE: begin
        if (item.valid) begin
          item_take = 1'b1;
          if (item.op == rcfft_pkg::OP_PUSH) begin
            if (!ready_r) begin
              we    = 1'b1;
              waddr = AW'(fill_r);
              wdata = {{(W-SB){item_imag[SB-1]}}, item_imag,
                       {(W-SB){item_real[SB-1]}}, item_real};
              fill_nxt = fill_r + CW'(1);
              if (fill_r + CW'(1) >= n_pts) begin
                fill_nxt   = '0;
                rd_idx_nxt = '0;
                if (eff_l == 4'd0) begin
                  ready_nxt = 1'b1;
                end else begin
                  stage_nxt = eff_l;
                  bf_nxt    = '0;
                  state_nxt = rcfft_pkg::ST_BF_RD;
                end
              end
            end
          end else begin
            re           = 1'b1;
            raddr_a      = pop_addr;
            pop_bv_nxt   = ready_r;
            pop_last_nxt = ready_r && (rd_idx_r + CW'(1) >= n_pts);
            if (ready_r) begin
              if (rd_idx_r + CW'(1) >= n_pts) begin
                rd_idx_nxt = '0;
                ready_nxt  = 1'b0;
              end else begin
                rd_idx_nxt = rd_idx_r + CW'(1);
              end
            end
            state_nxt = rcfft_pkg::ST_POP_OUT;
          end
        end
      end
      rcfft_pkg::ST_BF_RD: begin
        re        = 1'b1;
        state_nxt = rcfft_pkg::ST_BF_MUL;
      end
      rcfft_pkg::ST_BF_MUL: state_nxt = rcfft_pkg::ST_BF_SUM;
      rcfft_pkg::ST_BF_SUM: state_nxt = rcfft_pkg::ST_BF_WA;
      rcfft_pkg::ST_BF_WA: begin
        we        = 1'b1;
        state_nxt = rcfft_pkg::ST_BF_WB;
      end
      rcfft_pkg::ST_BF_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = {res_im_r, res_re_r};
        state_nxt = rcfft_pkg::ST_BF_RD;
        if (bf_r == AW'((n_pts >> 1) - CW'(1))) begin
          bf_nxt = '0;
          if (stage_r == 4'd1) begin
            ready_nxt = 1'b1;
            state_nxt = rcfft_pkg::ST_IDLE;
          end else begin
            stage_nxt = stage_r - 4'd1;
          end
        end else begin
          bf_nxt = bf_r + AW'(1);
        end
      end
      rcfft_pkg::ST_POP_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = rcfft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rcfft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= rcfft_pkg::DIR_FORWARD;
      log2_r      <= 4'd10;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      ready_r     <= 1'b0;
      stage_r     <= 4'd1;
      bf_r        <= '0;
      pop_bv_r    <= 1'b0;
      pop_last_r  <= 1'b0;
    end else begin
      stage_r    <= stage_nxt;
      bf_r       <= bf_nxt;
      pop_bv_r   <= pop_bv_nxt;
      pop_last_r <= pop_last_nxt;
      fill_r     <= fill_nxt;
      rd_idx_r   <= rd_idx_nxt;
      ready_r    <= ready_nxt;
      if (cfg_valid) begin
        if (cfg_index == rcfft_pkg::CFG_DIRECTION) begin
          direction_r <= cfg_wdata[0];
        end else begin
          log2_r   <= cfg_wdata;
          fill_r   <= '0;
          rd_idx_r <= '0;
          ready_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  assign dr = $signed({rd_a_r[W-1], rd_a_r[W-1:0]}) - $signed({rd_b_r[W-1], rd_b_r[W-1:0]});
  assign di = $signed({rd_a_r[2*W-1], rd_a_r[2*W-1:W]})
            - $signed({rd_b_r[2*W-1], rd_b_r[2*W-1:W]});

  always_ff @(posedge clk) begin
    if (state_r == rcfft_pkg::ST_BF_MUL) begin
      p_rc_r   <= dr * cos_r;
      p_is_r   <= di * sin_r;
      p_rs_r   <= dr * sin_r;
      p_ic_r   <= di * cos_r;
      sum_re_r <= W'(dr + $signed({rd_b_r[W-1], rd_b_r[W-1:0]})
                  + $signed({rd_b_r[W-1], rd_b_r[W-1:0]}));
      sum_im_r <= W'(di + $signed({rd_b_r[2*W-1], rd_b_r[2*W-1:W]})
                  + $signed({rd_b_r[2*W-1], rd_b_r[2*W-1:W]}));
    end
  end

  assign pr = $signed({p_rc_r[PW-1], p_rc_r}) - $signed({p_is_r[PW-1], p_is_r}) + RND;
  assign pi = $signed({p_rs_r[PW-1], p_rs_r}) + $signed({p_ic_r[PW-1], p_ic_r}) + RND;

  always_ff @(posedge clk) begin
    if (state_r == rcfft_pkg::ST_BF_SUM) begin
      res_re_r <= W'(pr >>> F);
      res_im_r <= W'(pi >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_real  <= pop_bv_r ? $signed(rd_a_r[W-1:0]) : '0;
      out_bin_imag  <= pop_bv_r ? $signed(rd_a_r[2*W-1:W]) : '0;
      out_bin_valid <= pop_bv_r;
      out_last_bin  <= pop_last_r;
    end
  end

endmodule
`default_nettype wire

[design/radix2_complex_fft_core.sv]
// Push: one word per cycle unless in_stall, via a two-entry queue into frame memory.
// Transform: each butterfly steps through read, multiply, sum, write-A and write-B states,
//   writing its outputs apart, as one frame-memory write port serves both of them.
// Pop: each word is read from frame memory, then loaded to the output once not stalled.
// Reset clears control, queue, length (1024 points) and direction (forward);
//   frame memory contents stay undefined until written.
`default_nettype none
module radix2_complex_fft_core #(
  parameter int MAX_LOG2_POINTS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int TWIDDLE_BITS    = 18
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         in_valid,
  output logic                                        in_stall,
  input  wire                                         in_command,
  input  wire  signed [SAMPLE_BITS-1:0]               in_sample_real,
  input  wire  signed [SAMPLE_BITS-1:0]               in_sample_imag,
  output logic                                        out_valid,
  input  wire                                         out_stall,
  output logic signed [SAMPLE_BITS+MAX_LOG2_POINTS:0] out_bin_real,
  output logic signed [SAMPLE_BITS+MAX_LOG2_POINTS:0] out_bin_imag,
  output logic                                        out_bin_valid,
  output logic                                        out_last_bin,
  input  wire                                         cfg_valid,
  output logic                                        cfg_ready,
  input  wire                                         cfg_index,
  input  wire  [rcfft_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  rcfft_pkg::item_ctl_t           item;
  logic signed [SAMPLE_BITS-1:0]  item_real, item_imag;
  logic                           item_take;

  assign cfg_ready = 1'b1;

  rcfft_front #(.SB(SAMPLE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_sample_real(in_sample_real),
    .in_sample_imag(in_sample_imag),
    .item          (item),
    .item_real     (item_real),
    .item_imag     (item_imag),
    .item_take     (item_take)
  );

  rcfft_back #(
    .MAXL(MAX_LOG2_POINTS),
    .SB  (SAMPLE_BITS),
    .TB  (TWIDDLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_real    (item_real),
    .item_imag    (item_imag),
    .item_take    (item_take),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin_real (out_bin_real),
    .out_bin_imag (out_bin_imag),
    .out_bin_valid(out_bin_valid),
    .out_last_bin (out_last_bin)
  );

endmodule
`default_nettype wire
